// ===== rtl/mrpt_pkg.sv =====
// Package with constants and types shared by the primality tester.
package mrpt_pkg;
	localparam int WordBitsDefault = 64;
	localparam int TrialCount = 12;
	localparam int BaseCount = 7;

	typedef struct packed {
		logic start;
		logic busy;
	} mul_ctl_t;

	function automatic logic [5:0] trial_prime(input logic [3:0] idx);
		logic [5:0] p;
		begin
			case (idx)
				4'd0: p = 6'd2;
				4'd1: p = 6'd3;
				4'd2: p = 6'd5;
				4'd3: p = 6'd7;
				4'd4: p = 6'd11;
				4'd5: p = 6'd13;
				4'd6: p = 6'd17;
				4'd7: p = 6'd19;
				4'd8: p = 6'd23;
				4'd9: p = 6'd29;
				4'd10: p = 6'd31;
				4'd11: p = 6'd37;
				default: p = 6'd2;
			endcase
			return p;
		end
	endfunction

	function automatic logic [30:0] mr_base(input logic [2:0] idx);
		logic [30:0] b;
		begin
			case (idx)
				3'd0: b = 31'd2;
				3'd1: b = 31'd325;
				3'd2: b = 31'd9375;
				3'd3: b = 31'd28178;
				3'd4: b = 31'd450775;
				3'd5: b = 31'd9780504;
				3'd6: b = 31'd1795265022;
				default: b = 31'd2;
			endcase
			return b;
		end
	endfunction
endpackage

// ===== rtl/mrpt_modmul.sv =====
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
module mrpt_modmul #(
	parameter int WordBits = mrpt_pkg::WordBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WordBits-1:0] x,
	input  logic [WordBits-1:0] y,
	input  logic [WordBits-1:0] m,
	output logic                done,
	output logic [WordBits-1:0] prod
);
	import mrpt_pkg::*;

	localparam int CntW = $clog2(WordBits + 1);

	logic [WordBits-1:0] acc_q, y_q, x_q, m_q;
	logic [CntW-1:0]     cnt_q;
	logic                run_q;
	logic [WordBits:0]   dbl, dred, sum;
	logic [WordBits-1:0] a1, a2;

	// Doubling then conditional add; each sum below 2m so one subtract corrects it.
	always_comb begin
		dbl  = {acc_q, 1'b0};
		dred = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		a1   = dred[WordBits-1:0];
		sum  = {1'b0, a1} + {1'b0, x_q};
		if (sum >= {1'b0, m_q}) begin
			sum = sum - {1'b0, m_q};
		end
		a2 = y_q[WordBits-1] ? sum[WordBits-1:0] : a1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= run_q && !start && (cnt_q == CntW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(WordBits);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			y_q   <= y;
			x_q   <= x;
			m_q   <= m;
		end else if (run_q) begin
			acc_q <= a2;
			y_q   <= {y_q[WordBits-2:0], 1'b0};
		end
	end

	assign prod = acc_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("done while running");
	assert property (@(posedge clk) disable iff (!arst_n) run_q |-> cnt_q != '0)
		else $error("zero count while running");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> run_q)
		else $error("start lost");
endmodule

// ===== rtl/mrpt_modred.sv =====
// Bit-serial remainder unit: reduces a value modulo a divisor, one bit per cycle.
module mrpt_modred #(
	parameter int WordBits = mrpt_pkg::WordBitsDefault,
	parameter int NumBits  = WordBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NumBits-1:0]  num,
	input  logic [WordBits-1:0] div,
	output logic                done,
	output logic [WordBits-1:0] rem
);
	import mrpt_pkg::*;

	localparam int CntW = $clog2(NumBits + 1);

	logic [WordBits-1:0] r_q, d_q;
	logic [NumBits-1:0]  n_q;
	logic [CntW-1:0]     cnt_q;
	logic                run_q;
	logic [WordBits:0]   sh;

	always_comb begin
		sh = {r_q, n_q[NumBits-1]};
		if (sh >= {1'b0, d_q}) begin
			sh = sh - {1'b0, d_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= run_q && !start && (cnt_q == CntW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(NumBits);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			n_q <= num;
			d_q <= div;
		end else if (run_q) begin
			r_q <= sh[WordBits-1:0];
			n_q <= {n_q[NumBits-2:0], 1'b0};
		end
	end

	assign rem = r_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("remainder done while running");
	assert property (@(posedge clk) disable iff (!arst_n) run_q && !start |-> r_q < d_q)
		else $error("partial remainder out of range");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> run_q)
		else $error("remainder start lost");
endmodule

// ===== rtl/miller_rabin_prime_test_64_top.sv =====
// Top level of the deterministic Miller-Rabin primality tester.
//
// Usage: one candidate enters as a transaction on the slave channel
// (s_axis_*); one transaction with prime_flag leaves on the master
// channel (m_axis_*). The block handles one candidate at a time:
// s_axis_tready is high only while the sequencer is idle.
// Operation: trial division by the twelve primes 2..37 runs in the
// bit-serial remainder unit. Then each of the seven bases needs one
// reduction of the base mod n, a square-and-multiply exponentiation and
// up to s-1 squarings, every modular product being formed in the
// bit-serial multiplier.
// The result sits in an output register; while the receiver holds
// m_axis_tready low, the result is held and no new candidate is taken.
// Reset returns the sequencer to idle and drops m_axis_tvalid.
module miller_rabin_prime_test_64_top #(
	parameter int WORD_BITS = mrpt_pkg::WordBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] candidate
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] prime_flag, [7:1] zero
);
	import mrpt_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int SW = $clog2(W + 1);
	// The remainder unit takes the whole 31-bit base even for narrow words.
	localparam int NW = (W > 31) ? W : 31;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_TRIAL  = 13'b0000000000010,
		ST_TWAIT  = 13'b0000000000100,
		ST_SPLIT  = 13'b0000000001000,
		ST_BASE   = 13'b0000000010000,
		ST_BWAIT  = 13'b0000000100000,
		ST_EBIT   = 13'b0000001000000,
		ST_MULA   = 13'b0000010000000,
		ST_SQB    = 13'b0000100000000,
		ST_CHECK  = 13'b0001000000000,
		ST_SQX    = 13'b0010000000000,
		ST_SQXW   = 13'b0100000000000,
		ST_OUT    = 13'b1000000000000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  n_q, d_q, e_q, acc_q, b_q;
	logic [SW-1:0] s_q, r_q;
	logic [3:0]    tidx_q;
	logic [2:0]    bidx_q;
	logic          flag_q;

	mul_ctl_t      mctl, rctl;
	logic [W-1:0]  mx, my, mprod, rdiv, rrem;
	logic [NW-1:0] rnum;
	logic          mdone, rdone;
	logic [W-1:0]  nm1;
	logic [5:0]    tp;

	assign nm1 = n_q - 1'b1;
	assign tp  = trial_prime(tidx_q);

	mrpt_modmul #(.WordBits(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mctl.start), .x(mx), .y(my),
		.m(n_q), .done(mdone), .prod(mprod)
	);

	mrpt_modred #(.WordBits(W), .NumBits(NW)) u_red (
		.clk(clk), .arst_n(arst_n), .start(rctl.start), .num(rnum), .div(rdiv),
		.done(rdone), .rem(rrem)
	);

	// Trial divisors are zero-extended to the word; the dividend is widened.
	always_comb begin
		rnum = NW'(n_q);
		rdiv = W'(tp);
		if (state_q == ST_BASE || state_q == ST_BWAIT) begin
			rnum = NW'(mr_base(bidx_q));
			rdiv = n_q;
		end
	end

	assign rctl.start = (state_q == ST_TRIAL) || (state_q == ST_BASE);
	assign rctl.busy  = (state_q == ST_TWAIT) || (state_q == ST_BWAIT);

	// Multiplier operands: acc*b when the exponent bit is set, else b*b, or acc*acc in SQX.
	always_comb begin
		mx = b_q;
		my = b_q;
		if (state_q == ST_EBIT && e_q[0]) begin
			mx = acc_q;
		end else if (state_q == ST_SQX) begin
			mx = acc_q;
			my = acc_q;
		end
	end

	// The squaring of b starts as soon as the product acc*b is done.
	assign mctl.start = (state_q == ST_EBIT && e_q != '0) || (state_q == ST_SQX) ||
		(state_q == ST_MULA && mdone);
	assign mctl.busy  = (state_q == ST_MULA) || (state_q == ST_SQB) || (state_q == ST_SQXW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_TRIAL;
					end
				end
				ST_TRIAL: state_q <= ST_TWAIT;
				ST_TWAIT: begin
					if (rdone) begin
						if (n_q < W'(2)) begin
							state_q <= ST_OUT;
						end else if (rrem == '0) begin
							state_q <= ST_OUT;
						end else if (tidx_q == 4'(TrialCount - 1)) begin
							state_q <= ST_SPLIT;
						end else begin
							state_q <= ST_TRIAL;
						end
					end
				end
				ST_SPLIT: begin
					if (d_q[0]) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: state_q <= ST_BWAIT;
				ST_BWAIT: begin
					if (rdone) begin
						state_q <= (rrem == '0) ? ST_CHECK : ST_EBIT;
					end
				end
				ST_EBIT: begin
					if (e_q == '0) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= e_q[0] ? ST_MULA : ST_SQB;
					end
				end
				ST_MULA: begin
					if (mdone) begin
						state_q <= ST_SQB;
					end
				end
				ST_SQB: begin
					if (mdone) begin
						state_q <= ST_EBIT;
					end
				end
				ST_CHECK: begin
					// Branch back into squaring while rounds remain.
					if (flag_q && r_q != '0) begin
						state_q <= ST_SQX;
					end else if (!flag_q || bidx_q == 3'(BaseCount - 1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_BASE;
					end
				end
				ST_SQX: state_q <= ST_SQXW;
				ST_SQXW: begin
					if (mdone) begin
						state_q <= ST_CHECK;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers. In CHECK, r_q counts remaining squarings and flag_q
	// means "this base still undecided or passed"; a pending round uses r_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			tidx_q <= '0;
			bidx_q <= '0;
			r_q    <= '0;
			s_q    <= '0;
			n_q    <= '0;
			d_q    <= '0;
			e_q    <= '0;
			acc_q  <= '0;
			b_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					tidx_q <= '0;
					bidx_q <= '0;
					flag_q <= 1'b0;
					n_q    <= s_axis_tdata[W-1:0];
				end
				ST_TWAIT: begin
					if (rdone) begin
						tidx_q <= tidx_q + 1'b1;
						if (n_q >= W'(2) && rrem == '0) begin
							flag_q <= (n_q == W'(tp));
						end
					end
					d_q <= nm1;
					s_q <= '0;
				end
				ST_SPLIT: begin
					if (!d_q[0]) begin
						d_q <= {1'b0, d_q[W-1:1]};
						s_q <= s_q + 1'b1;
					end
					flag_q <= 1'b1;
				end
				ST_BWAIT: begin
					b_q   <= rrem;
					e_q   <= d_q;
					acc_q <= W'(1);
					r_q   <= '0;
				end
				ST_EBIT: begin
					if (e_q == '0) begin
						// Exponentiation finished: decide or set up squarings.
						if (acc_q == W'(1) || acc_q == nm1) begin
							r_q <= '0;
						end else if (s_q > SW'(1)) begin
							r_q    <= s_q - 1'b1;
							flag_q <= 1'b1;
						end else begin
							flag_q <= 1'b0;
						end
					end
				end
				ST_MULA: begin
					if (mdone) begin
						acc_q <= mprod;
					end
				end
				ST_SQB: begin
					if (mdone) begin
						b_q <= mprod;
						e_q <= {1'b0, e_q[W-1:1]};
					end
				end
				ST_CHECK: begin
					if (!(flag_q && r_q != '0) && flag_q) begin
						bidx_q <= bidx_q + 1'b1;
					end
				end
				ST_SQXW: begin
					if (mdone) begin
						acc_q <= mprod;
						if (mprod == nm1) begin
							r_q <= '0;
						end else if (r_q == SW'(1)) begin
							r_q    <= '0;
							flag_q <= 1'b0;
						end else begin
							r_q <= r_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {7'd0, flag_q};

	assert property (@(posedge clk) disable iff (!arst_n) !(mctl.start && rctl.start))
		else $error("both serial units started");
	assert property (@(posedge clk) disable iff (!arst_n) mctl.busy |-> !rctl.busy)
		else $error("units busy together");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n) s_axis_tready |-> !m_axis_tvalid)
		else $error("accepting while result pending");
endmodule
